### rtl/ncs_pkg.sv
`timescale 1ns / 1ps
// Package for the comment-stripping string escaper.
// Scan mode codes, character constants, result burst type and its append helper.
package ncs_pkg;

    localparam int MAX_OUT = 6;
    localparam int CNT_W   = 3;

    localparam logic [2:0] MODE_NORMAL        = 3'd0;
    localparam logic [2:0] MODE_PAREN         = 3'd1;
    localparam logic [2:0] MODE_COMMENT       = 3'd2;
    localparam logic [2:0] MODE_COMMENT_PAREN = 3'd3;
    localparam logic [2:0] MODE_COMMENT_STAR  = 3'd4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_N      = 8'h6E;

    typedef struct packed {
        logic [2:0] mode;
        logic       quote;
    } t_scan;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] chars;
        logic [CNT_W-1:0]        cnt;
    } t_burst;

    function automatic t_burst put_char(t_burst b, logic [7:0] ch);
        t_burst r;
        r = b;
        if (r.cnt < CNT_W'(MAX_OUT)) begin
            r.chars[r.cnt] = ch;
            r.cnt          = r.cnt + 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/ncs_scan.sv
`timescale 1ns / 1ps
// Next-state and result logic for one text byte or end marker.
// Depends on ncs_pkg.
module ncs_scan #(
    parameter int MAX_NEST_DEPTH = 255,
    parameter int DW             = 8
) (
    input  ncs_pkg::t_scan  i_scan,
    input  logic [DW-1:0]   i_depth,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output ncs_pkg::t_scan  o_scan,
    output logic [DW-1:0]   o_depth,
    output ncs_pkg::t_burst o_burst
);
    import ncs_pkg::*;

    t_burst        b;
    t_scan         n_scan;
    logic [DW-1:0] n_depth;
    logic          plain;

    always_comb begin
        b       = '0;
        n_scan  = i_scan;
        n_depth = i_depth;
        plain   = 1'b0;
        if (!i_scan.quote) begin
            b            = put_char(b, CH_QUOTE);
            n_scan.quote = 1'b1;
        end
        if (i_last) begin
            if (i_scan.mode == MODE_PAREN) begin
                b = put_char(b, CH_LPAREN);
            end
            b            = put_char(b, CH_QUOTE);
            n_scan.mode  = MODE_NORMAL;
            n_scan.quote = 1'b0;
            n_depth      = '0;
        end else begin
            unique case (i_scan.mode)
                MODE_PAREN: begin
                    if (i_byte == CH_STAR) begin
                        n_depth     = DW'(1);
                        n_scan.mode = MODE_COMMENT;
                    end else begin
                        b           = put_char(b, CH_LPAREN);
                        n_scan.mode = MODE_NORMAL;
                        plain       = 1'b1;
                    end
                end
                MODE_COMMENT, MODE_COMMENT_PAREN, MODE_COMMENT_STAR: begin
                    priority if (i_scan.mode == MODE_COMMENT_PAREN && i_byte == CH_STAR) begin
                        if (i_depth < DW'(MAX_NEST_DEPTH)) begin
                            n_depth = i_depth + 1'b1;
                        end
                        n_scan.mode = MODE_COMMENT;
                    end else if (i_scan.mode == MODE_COMMENT_STAR && i_byte == CH_RPAREN) begin
                        if (i_depth <= DW'(1)) begin
                            n_depth     = '0;
                            n_scan.mode = MODE_NORMAL;
                        end else begin
                            n_depth     = i_depth - 1'b1;
                            n_scan.mode = MODE_COMMENT;
                        end
                    end else if (i_byte == CH_LPAREN) begin
                        n_scan.mode = MODE_COMMENT_PAREN;
                    end else if (i_byte == CH_STAR) begin
                        n_scan.mode = MODE_COMMENT_STAR;
                    end else begin
                        n_scan.mode = MODE_COMMENT;
                    end
                end
                default: begin
                    n_scan.mode = MODE_NORMAL;
                    plain       = 1'b1;
                end
            endcase
            if (plain) begin
                unique case (i_byte)
                    CH_QUOTE: begin
                        b = put_char(b, CH_BSLASH);
                        b = put_char(b, CH_QUOTE);
                    end
                    CH_BSLASH: begin
                        b = put_char(b, CH_BSLASH);
                        b = put_char(b, CH_BSLASH);
                    end
                    CH_CR: begin
                    end
                    CH_LF: begin
                        b = put_char(b, CH_BSLASH);
                        b = put_char(b, CH_N);
                        b = put_char(b, CH_QUOTE);
                        b = put_char(b, CH_LF);
                        b = put_char(b, CH_QUOTE);
                    end
                    CH_LPAREN: begin
                        n_scan.mode = MODE_PAREN;
                    end
                    default: begin
                        b = put_char(b, i_byte);
                    end
                endcase
            end
        end
    end

    assign o_scan  = n_scan;
    assign o_depth = n_depth;
    assign o_burst = b;

endmodule

### rtl/ncs_emit.sv
`timescale 1ns / 1ps
// Result register: holds up to six characters of one item and sends them in order.
// Depends on ncs_pkg.
module ncs_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ncs_pkg::t_burst i_burst,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [7:0]      o_data,
    output logic            o_last,
    output logic            o_load_ok
);
    import ncs_pkg::*;

    logic [MAX_OUT-1:0][7:0] r_chars;
    logic [CNT_W-1:0]        r_cnt;
    logic                    fire;

    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_chars[0];
    assign o_last    = (r_cnt == CNT_W'(1));
    assign fire      = o_valid && i_ready;
    assign o_load_ok = !o_valid || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // shift the next character down on each transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_burst.chars;
        end else if (fire) begin
            r_chars <= {8'h00, r_chars[MAX_OUT-1:1]};
        end
    end

endmodule

### rtl/nested_comment_strip_string_escape.sv
`timescale 1ns / 1ps
// Top level of the comment-stripping string escaper: input register, scan state,
// scan logic and result register. Depends on ncs_pkg, ncs_scan, ncs_emit.
//
//  channel  | direction | tdata                    | tlast
//  s_axis   | in        | [7:0] text_byte          | end_of_text
//  m_axis   | out       | [7:0] out_char           | last_of_run
//
// Scan logic between input and result registers is combinational. One character leaves
// per cycle while the output is ready; an item giving one character thus sustains one
// item per cycle. An item giving more characters holds the input until its last one has
// left the single result register port. Items giving no character send nothing.
// Reset is synchronous, active low, and clears the scan state and the valid state
// of both registers.
// A stalled output keeps one item waiting in the input register.
module nested_comment_strip_string_escape #(
    parameter int MAX_NEST_DEPTH = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic       o_m_axis_tlast    // last_of_run
);
    import ncs_pkg::*;

    localparam int DW = $clog2(MAX_NEST_DEPTH + 1);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    t_scan         r_scan;
    logic [DW-1:0] r_depth;

    t_scan         n_scan;
    logic [DW-1:0] n_depth;
    t_burst        burst;
    logic          load_ok;
    logic          consume;
    logic          in_xfer;

    assign consume         = r_in_valid && load_ok;
    assign o_s_axis_tready = !r_in_valid || consume;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '{mode: MODE_NORMAL, quote: 1'b0};
            r_depth <= '0;
        end else if (consume) begin
            r_scan  <= n_scan;
            r_depth <= n_depth;
        end
    end

    ncs_scan #(
        .MAX_NEST_DEPTH(MAX_NEST_DEPTH),
        .DW            (DW)
    ) u_scan (
        .i_scan (r_scan),
        .i_depth(r_depth),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_scan (n_scan),
        .o_depth(n_depth),
        .o_burst(burst)
    );

    ncs_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume),
        .i_burst  (burst),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .o_load_ok(load_ok)
    );

endmodule

### rtl/ncs_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the comment-stripping string escaper, bound to the top level.
// Depends on nested_comment_strip_string_escape ports only.
module ncs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tlast))
        else $error("input changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    a_no_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata != 8'h0D)
        else $error("carriage return sent");

    a_lf_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata == 8'h0A |-> !o_m_axis_tlast)
        else $error("newline ends a transfer run");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input held with no output pending");

endmodule

bind nested_comment_strip_string_escape ncs_chk u_ncs_chk (.*);

### tb/sv/tb_nested_comment_strip_string_escape.sv
`timescale 1ns / 1ps
// Self-checking testbench for the comment-stripping string escaper.
// Predicts each escaped character from the input bytes and checks every transfer out.
// Depends on ncs_pkg and nested_comment_strip_string_escape.
module tb_nested_comment_strip_string_escape;
    import ncs_pkg::*;

    localparam int NEST_MAX     = 255;
    localparam int NEST_STEPS   = 6;
    localparam int RANDOM_ITEMS = 224;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;  // [7:0] text_byte
    logic       i_s_axis_tlast  = 1'b0;   // end_of_text
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_char
    logic       o_m_axis_tlast;           // last_of_run

    t_out_char  escaped_q[$];
    int         mismatches  = 0;

    logic [2:0]  scan_mode  = MODE_NORMAL;
    logic [15:0] nest_level = '0;
    logic        quote_open = 1'b0;
    logic [7:0]  burst_chars[MAX_OUT];
    int          burst_cnt  = 0;

    int          burst_left = 0;
    int          rx_mode    = 0;
    int          rx_left    = 0;
    logic [7:0]  rx_mask    = 8'h01;

    nested_comment_strip_string_escape #(
        .MAX_NEST_DEPTH(NEST_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void add_char(input logic [7:0] ch);
        if (burst_cnt < MAX_OUT) begin
            burst_chars[burst_cnt] = ch;
            burst_cnt++;
        end
    endfunction

    function automatic void escape_plain(input logic [7:0] b);
        case (b)
            CH_QUOTE: begin
                add_char(CH_BSLASH);
                add_char(CH_QUOTE);
            end
            CH_BSLASH: begin
                add_char(CH_BSLASH);
                add_char(CH_BSLASH);
            end
            CH_CR: ;
            CH_LF: begin
                add_char(CH_BSLASH);
                add_char(CH_N);
                add_char(CH_QUOTE);
                add_char(CH_LF);
                add_char(CH_QUOTE);
            end
            CH_LPAREN: scan_mode = MODE_PAREN;
            default: add_char(b);
        endcase
    endfunction

    function automatic void predict_escape(input logic [7:0] b, input logic eot);
        burst_cnt = 0;
        if (!quote_open) begin
            add_char(CH_QUOTE);
            quote_open = 1'b1;
        end
        if (eot) begin
            if (scan_mode == MODE_PAREN)
                add_char(CH_LPAREN);
            add_char(CH_QUOTE);
            scan_mode  = MODE_NORMAL;
            nest_level = '0;
            quote_open = 1'b0;
        end else begin
            case (scan_mode)
                MODE_PAREN: begin
                    if (b == CH_STAR) begin
                        nest_level = 16'd1;
                        scan_mode  = MODE_COMMENT;
                    end else begin
                        add_char(CH_LPAREN);
                        scan_mode = MODE_NORMAL;
                        escape_plain(b);
                    end
                end
                MODE_COMMENT, MODE_COMMENT_PAREN, MODE_COMMENT_STAR: begin
                    if (scan_mode == MODE_COMMENT_PAREN && b == CH_STAR) begin
                        if (nest_level < NEST_MAX)
                            nest_level++;
                        scan_mode = MODE_COMMENT;
                    end else if (scan_mode == MODE_COMMENT_STAR && b == CH_RPAREN) begin
                        if (nest_level <= 16'd1) begin
                            nest_level = '0;
                            scan_mode  = MODE_NORMAL;
                        end else begin
                            nest_level--;
                            scan_mode = MODE_COMMENT;
                        end
                    end else if (b == CH_LPAREN) begin
                        scan_mode = MODE_COMMENT_PAREN;
                    end else if (b == CH_STAR) begin
                        scan_mode = MODE_COMMENT_STAR;
                    end else begin
                        scan_mode = MODE_COMMENT;
                    end
                end
                default: begin
                    scan_mode = MODE_NORMAL;
                    escape_plain(b);
                end
            endcase
        end
        for (int k = 0; k < burst_cnt; k++)
            escaped_q.push_back('{ch: burst_chars[k], last: (k == burst_cnt - 1)});
    endfunction

    // Hold tvalid across a burst; drop it only for a gap between bursts.
    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_escape(b, eot);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_end();
    endtask

    task automatic test_escapes();
        send_item(CH_CR, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_LF, 1'b0);
        send_end();
    endtask

    task automatic test_held_paren();
        send_item(CH_LPAREN, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(CH_LPAREN, 1'b0);
        send_item(CH_LPAREN, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_LPAREN, 1'b0);
        send_end();
    endtask

    task automatic test_nested_comments();
        send_text("(*(*)*)**)y");
        send_text("(*");
        send_end();
        send_end();
    endtask

    // Open several levels, close them all, then resume plain text.
    task automatic test_deep_nesting();
        for (int i = 0; i < NEST_STEPS; i++)
            send_text("(*");
        for (int i = 0; i < NEST_STEPS; i++)
            send_text("*)");
        send_item(8'h7A, 1'b0);
        send_end();
    endtask

    task automatic test_random_text();
        int r;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_end();
                sent++;
            end else if (r < 15) begin
                send_text("(*");
                sent += 2;
            end else if (r < 27) begin
                send_text("*)");
                sent += 2;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 18)      send_item(CH_LPAREN, 1'b0);
                else if (r < 30) send_item(CH_STAR, 1'b0);
                else if (r < 42) send_item(CH_RPAREN, 1'b0);
                else if (r < 48) send_item(CH_QUOTE, 1'b0);
                else if (r < 54) send_item(CH_BSLASH, 1'b0);
                else if (r < 58) send_item(CH_CR, 1'b0);
                else if (r < 64) send_item(CH_LF, 1'b0);
                else             send_item(8'($urandom_range(0, 255)), 1'b0);
                sent++;
            end
        end
        send_end();
    endtask

    // Receiver: switch between always ready, random, sparse and a rotating mask.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
            rx_mask <= 8'($urandom) | 8'h01;
        end else begin
            rx_left <= rx_left - 1;
            rx_mask <= {rx_mask[0], rx_mask[7:1]};
        end
        case (rx_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
            2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_axis_tready <= rx_mask[0];
        endcase
    end

    always @(posedge i_clk) begin
        t_out_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (escaped_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char 8'h%02h last %0b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = escaped_q.pop_front();
                if (o_m_axis_tdata !== want.ch)
                    report_mismatch($sformatf("out_char 8'h%02h, expected 8'h%02h",
                                              o_m_axis_tdata, want.ch));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b for 8'h%02h",
                                              o_m_axis_tlast, want.last, want.ch));
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_byte_extremes();
        test_escapes();
        test_held_paren();
        test_nested_comments();
        test_deep_nesting();
        test_random_text();
        i_s_axis_tvalid <= 1'b0;
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
